// File: rtl/boot_image_crc_validator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the boot image CRC validator
// Immediate-consequence and next-cycle property checks, removable as a group.
// ----------------------------------------------------------------------------
`ifndef BOOT_IMAGE_CRC_VALIDATOR_UNIT_MACROS_SVH
`define BOOT_IMAGE_CRC_VALIDATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BICV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BICV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BICV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BICV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/bicv_pkg.sv
// ----------------------------------------------------------------------------
// Boot image CRC validator package
// Request and result types, header layout, verdict codes and the CRC step.
// ----------------------------------------------------------------------------
package bicv_pkg;

	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] SIG_RESET = 32'hA5A5_A5A5;

	localparam logic [5:0] HDR_CRC_BYTES = 6'd28;
	localparam logic [5:0] OFF_SIG_END   = 6'd3;
	localparam logic [5:0] OFF_LEN_END   = 6'd15;
	localparam logic [5:0] OFF_DCRC_END  = 6'd19;
	localparam logic [5:0] OFF_HDR_END   = 6'd31;

	localparam logic [1:0] VERDICT_VALID    = 2'd0;
	localparam logic [1:0] VERDICT_BAD_SIG  = 2'd1;
	localparam logic [1:0] VERDICT_BAD_HCRC = 2'd2;
	localparam logic [1:0] VERDICT_BAD_DCRC = 2'd3;

	typedef struct packed {
		logic [7:0] image_byte;
		logic       image_start;
	} bicv_in_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [31:0] payload_length;
		logic [31:0] computed_crc;
	} bicv_out_t;

	typedef struct packed {
		logic      emit;
		bicv_out_t result;
	} bicv_core_rsp_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/boot_image_crc_validator_unit.sv
// An accepted byte is held in the input register; when the result register has
// room, the verdict it causes is loaded into the result register.
// Throughput: one image byte per cycle, set by the byte-wide CRC-32 step
// between the input register and the result register; a verdict held by the
// receiver stalls the input until it is taken.
// Reset: control state returns to idle and the signature to A5A5A5A5 at once.
// ----------------------------------------------------------------------------
// Boot image CRC validator
// Checks header signature, header CRC and data CRC of a streamed flash image.
// ----------------------------------------------------------------------------
`include "boot_image_crc_validator_unit_macros.svh"

module boot_image_crc_validator_unit import bicv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  bicv_in_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bicv_out_t   out_data
);

	logic           valid_s1;
	bicv_in_t       data_s1;
	logic [31:0]    signature_q;
	logic           slot_free;
	logic           adv;
	bicv_core_rsp_t rsp;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && slot_free;
	assign in_ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signature_q <= SIG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			signature_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	bicv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (data_s1),
		.signature (signature_q),
		.rsp       (rsp)
	);

	bicv_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && rsp.emit),
		.result    (rsp.result),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`BICV_ASSERT_IMP(a_sig_fields_zero, clk, arst_n, out_valid && out_data.verdict == VERDICT_BAD_SIG, out_data.payload_length == 32'd0 && out_data.computed_crc == 32'd0, "bad signature verdict carries nonzero fields")
	`BICV_ASSERT_IMP(a_stall_needs_item, clk, arst_n, !in_ready, valid_s1 && out_valid && !out_ready, "input stalled without a held request")
	`BICV_ASSERT_NXT(a_drain_clears, clk, arst_n, out_valid && out_ready && !(adv && rsp.emit), !out_valid, "result register did not drain")

endmodule

// File: rtl/bicv_core.sv
// ----------------------------------------------------------------------------
// Boot image CRC validator core
// Header parse, signature and CRC checks, one byte per advance.
// ----------------------------------------------------------------------------
module bicv_core import bicv_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  bicv_in_t       item,
	input  logic [31:0]    signature,
	output bicv_core_rsp_t rsp
);

	typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_DATA, PH_DONE} phase_t;

	phase_t      phase_q, phase_d, ph;
	logic [5:0]  hoff_q, hoff_d, off;
	logic [31:0] drem_q, drem_d, drem;
	logic [31:0] crc_q, crc_d, crc;
	logic [31:0] word_q, word_d, word;
	logic [31:0] len_q, len_d, len;
	logic [31:0] dcrc_q, dcrc_d, dcrc;
	logic [31:0] crc_step;

	always_comb begin
		ph   = item.image_start ? PH_HEADER : phase_q;
		off  = item.image_start ? 6'd0 : hoff_q;
		drem = item.image_start ? 32'd0 : drem_q;
		crc  = item.image_start ? CRC_INIT : crc_q;
		word = item.image_start ? 32'd0 : word_q;
		len  = item.image_start ? 32'd0 : len_q;
		dcrc = item.image_start ? 32'd0 : dcrc_q;

		crc_step = crc_byte(crc, item.image_byte);

		phase_d = ph;
		hoff_d  = off;
		drem_d  = drem;
		crc_d   = crc;
		word_d  = word;
		len_d   = len;
		dcrc_d  = dcrc;
		rsp     = '0;

		unique case (ph)
			PH_HEADER: begin
				word_d = {item.image_byte, word[31:8]};
				if (off < HDR_CRC_BYTES) begin
					crc_d = crc_step;
				end
				hoff_d = off + 6'd1;
				if (off == OFF_SIG_END) begin
					if (word_d != signature) begin
						rsp.emit           = 1'b1;
						rsp.result.verdict = VERDICT_BAD_SIG;
						phase_d            = PH_DONE;
					end
				end else if (off == OFF_LEN_END) begin
					len_d = word_d;
				end else if (off == OFF_DCRC_END) begin
					dcrc_d = word_d;
				end else if (off == OFF_HDR_END) begin
					if (word_d != crc_d) begin
						rsp.emit                  = 1'b1;
						rsp.result.verdict        = VERDICT_BAD_HCRC;
						rsp.result.payload_length = len;
						rsp.result.computed_crc   = crc_d;
						phase_d                   = PH_DONE;
					end else begin
						crc_d  = CRC_INIT;
						drem_d = len;
						if (len == 32'd0) begin
							rsp.emit                  = 1'b1;
							rsp.result.verdict        = (CRC_INIT == dcrc) ?
								VERDICT_VALID : VERDICT_BAD_DCRC;
							rsp.result.payload_length = len;
							rsp.result.computed_crc   = CRC_INIT;
							phase_d                   = PH_DONE;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
			end
			PH_DATA: begin
				crc_d  = crc_step;
				drem_d = drem - 32'd1;
				if (drem_d == 32'd0) begin
					rsp.emit                  = 1'b1;
					rsp.result.verdict        = (crc_step == dcrc) ?
						VERDICT_VALID : VERDICT_BAD_DCRC;
					rsp.result.payload_length = len;
					rsp.result.computed_crc   = crc_step;
					phase_d                   = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hoff_q  <= '0;
			drem_q  <= '0;
			crc_q   <= CRC_INIT;
			word_q  <= '0;
			len_q   <= '0;
			dcrc_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			hoff_q  <= hoff_d;
			drem_q  <= drem_d;
			crc_q   <= crc_d;
			word_q  <= word_d;
			len_q   <= len_d;
			dcrc_q  <= dcrc_d;
		end
	end

endmodule

// File: rtl/bicv_out_stage.sv
// ----------------------------------------------------------------------------
// Boot image CRC validator result register
// Holds one verdict until taken; frees its slot in the cycle it drains.
// ----------------------------------------------------------------------------
module bicv_out_stage import bicv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  bicv_out_t result,
	output logic      slot_free,
	output logic      out_valid,
	input  logic      out_ready,
	output bicv_out_t out_data
);

	logic      valid_q;
	bicv_out_t data_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

// File: test/image_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Image verdict checker
// Watches the signature, byte and verdict channels of the boot image CRC
// validator, tracks header, CRC and data state per image, queues each
// verdict that accepted bytes should cause and compares every delivered verdict.
// ----------------------------------------------------------------------------
module image_verdict_checker import bicv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  bicv_in_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  bicv_out_t   out_data,
	output int          fail_count,
	output int          pending_verdicts,
	output int          verdicts_checked,
	output int          valid_verdicts
);

	typedef enum logic [1:0] {ST_IDLE, ST_HEADER, ST_DATA, ST_DONE} image_stage_t;

	image_stage_t stage;
	logic [31:0]  sig_reg;
	logic [5:0]   hdr_pos;
	logic [31:0]  bytes_left;
	logic [31:0]  crc_acc;
	logic [31:0]  shift_word;
	logic [31:0]  len_word;
	logic [31:0]  dcrc_word;
	bicv_out_t    expected_verdicts[$];
	int           mismatches;
	int           checked;
	int           valids;

	function automatic logic [31:0] crc_shift_in(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	task automatic finish_image(input logic [1:0] v, input logic [31:0] len, input logic [31:0] crc);
		bicv_out_t res;
		res.verdict        = v;
		res.payload_length = len;
		res.computed_crc   = crc;
		expected_verdicts.push_back(res);
		stage = ST_DONE;
	endtask

	task automatic absorb_byte(input bicv_in_t req);
		logic [5:0] pos;
		if (req.image_start) begin
			stage      = ST_HEADER;
			hdr_pos    = '0;
			bytes_left = '0;
			crc_acc    = CRC_INIT;
			shift_word = '0;
			len_word   = '0;
			dcrc_word  = '0;
		end
		case (stage)
			ST_HEADER: begin
				pos = hdr_pos;
				shift_word = {req.image_byte, shift_word[31:8]};
				if (pos < HDR_CRC_BYTES)
					crc_acc = crc_shift_in(crc_acc, req.image_byte);
				hdr_pos = pos + 6'd1;
				if (pos == OFF_SIG_END) begin
					if (shift_word != sig_reg)
						finish_image(VERDICT_BAD_SIG, 32'd0, 32'd0);
				end else if (pos == OFF_LEN_END) begin
					len_word = shift_word;
				end else if (pos == OFF_DCRC_END) begin
					dcrc_word = shift_word;
				end else if (pos == OFF_HDR_END) begin
					if (shift_word != crc_acc) begin
						finish_image(VERDICT_BAD_HCRC, len_word, crc_acc);
					end else begin
						crc_acc    = CRC_INIT;
						bytes_left = len_word;
						if (bytes_left == 0)
							finish_image((crc_acc == dcrc_word) ? VERDICT_VALID : VERDICT_BAD_DCRC,
								len_word, crc_acc);
						else
							stage = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				crc_acc    = crc_shift_in(crc_acc, req.image_byte);
				bytes_left = bytes_left - 32'd1;
				if (bytes_left == 0)
					finish_image((crc_acc == dcrc_word) ? VERDICT_VALID : VERDICT_BAD_DCRC,
						len_word, crc_acc);
			end
			default: ;
		endcase
	endtask

	task automatic compare_verdict(input bicv_out_t got);
		bicv_out_t want;
		if (expected_verdicts.size() == 0) begin
			$error("verdict %0d delivered with none expected", got.verdict);
			mismatches++;
		end else begin
			want = expected_verdicts.pop_front();
			checked++;
			if (want.verdict == VERDICT_VALID)
				valids++;
			if (got.verdict !== want.verdict) begin
				$error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
				mismatches++;
			end
			if (got.payload_length !== want.payload_length) begin
				$error("payload_length: expected %h, actual %h",
					want.payload_length, got.payload_length);
				mismatches++;
			end
			if (got.computed_crc !== want.computed_crc) begin
				$error("computed_crc: expected %h, actual %h", want.computed_crc, got.computed_crc);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_reg    = SIG_RESET;
			stage      = ST_IDLE;
			hdr_pos    = '0;
			bytes_left = '0;
			crc_acc    = CRC_INIT;
			shift_word = '0;
			len_word   = '0;
			dcrc_word  = '0;
			expected_verdicts.delete();
			mismatches = 0;
			checked    = 0;
			valids     = 0;
		end else begin
			if (out_valid && out_ready)
				compare_verdict(out_data);
			if (cfg_valid && cfg_ready)
				sig_reg = cfg_data;
			if (in_valid && in_ready)
				absorb_byte(in_data);
		end
		fail_count       <= mismatches;
		pending_verdicts <= expected_verdicts.size();
		verdicts_checked <= checked;
		valid_verdicts   <= valids;
	end

endmodule

// File: test/boot_image_crc_validator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Boot image CRC validator testbench
// Streams directed and random flash images (good, bad signature, bad header
// CRC, bad data CRC, truncated, noise) under several signature settings with
// random gaps and stalls on both sides; the checker predicts every verdict.
// ----------------------------------------------------------------------------
module boot_image_crc_validator_unit_tb;
	import bicv_pkg::*;

	typedef enum int {IMG_GOOD, IMG_BAD_SIG, IMG_BAD_HCRC, IMG_BAD_DCRC, IMG_CUT, IMG_NOISE}
		image_kind_t;

	localparam int TARGET_BYTES  = 1700;
	localparam int MIN_VERDICTS  = 48;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 6;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	bicv_in_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	bicv_out_t   out_data;

	int fail_count;
	int pending_verdicts;
	int verdicts_checked;
	int valid_verdicts;

	logic [31:0] cur_sig       = SIG_RESET;
	int          sig_settings  = 1;
	int          bytes_sent    = 0;
	bit          sender_burst  = 1'b0;
	bit          receiver_burst = 1'b0;
	bit          hold_req      = 1'b0;
	logic [7:0]  image_q[$];

	boot_image_crc_validator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	image_verdict_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_data         (out_data),
		.fail_count       (fail_count),
		.pending_verdicts (pending_verdicts),
		.verdicts_checked (verdicts_checked),
		.valid_verdicts   (valid_verdicts)
	);

	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("FAIL boot_image_crc_validator_unit");
		$finish;
	end

	function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic logic [31:0] flip_mask();
		return $urandom | (32'h1 << $urandom_range(0, 31));
	endfunction

	task automatic offer_byte(input logic [7:0] b, input logic s, input bit counted);
		bicv_in_t req;
		int gap;
		req.image_byte  = b;
		req.image_start = s;
		gap = sender_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		if (counted)
			bytes_sent++;
	endtask

	task automatic build_image(input logic [31:0] sig, input logic [31:0] len_word,
		input int data_len, input image_kind_t kind);
		logic [7:0]  data_q[$];
		logic [31:0] words[8];
		logic [31:0] dcrc;
		logic [31:0] hcrc;
		for (int i = 0; i < data_len; i++)
			data_q.push_back(8'($urandom));
		dcrc = CRC_INIT;
		foreach (data_q[i])
			dcrc = crc_next(dcrc, data_q[i]);
		words[0] = (kind == IMG_BAD_SIG) ? (sig ^ flip_mask()) : sig;
		words[1] = $urandom;
		words[2] = $urandom;
		words[3] = len_word;
		words[4] = (kind == IMG_BAD_DCRC) ? (dcrc ^ flip_mask()) : dcrc;
		words[5] = $urandom;
		words[6] = $urandom;
		image_q.delete();
		for (int w = 0; w < 7; w++)
			for (int k = 0; k < 4; k++)
				image_q.push_back(words[w][8*k +: 8]);
		hcrc = CRC_INIT;
		foreach (image_q[i])
			hcrc = crc_next(hcrc, image_q[i]);
		words[7] = (kind == IMG_BAD_HCRC) ? (hcrc ^ flip_mask()) : hcrc;
		for (int k = 0; k < 4; k++)
			image_q.push_back(words[7][8*k +: 8]);
		foreach (data_q[i])
			image_q.push_back(data_q[i]);
	endtask

	task automatic play_image(input int keep, input bit tail);
		for (int i = 0; i < keep && i < image_q.size(); i++)
			offer_byte(image_q[i], i == 0, 1'b1);
		// trailing bytes after the verdict, dropped by the block
		if (tail)
			repeat ($urandom_range(1, 3)) offer_byte(8'($urandom), 1'b0, 1'b0);
	endtask

	task automatic random_image();
		int r;
		int data_len;
		image_kind_t kind;
		if ($urandom_range(0, 7) == 0)
			sender_burst = !sender_burst;
		r = $urandom_range(0, 99);
		kind = (r < 40) ? IMG_GOOD : (r < 52) ? IMG_BAD_DCRC : (r < 62) ? IMG_BAD_HCRC :
			(r < 72) ? IMG_BAD_SIG : (r < 84) ? IMG_CUT : IMG_NOISE;
		data_len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 200) : $urandom_range(0, 16);
		case (kind)
			IMG_NOISE: begin
				repeat ($urandom_range(1, 8))
					offer_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
			end
			IMG_CUT: begin
				build_image(cur_sig, $urandom, data_len, IMG_GOOD);
				play_image($urandom_range(1, image_q.size()), 1'b0);
			end
			IMG_BAD_SIG: begin
				build_image(cur_sig, data_len, 0, kind);
				play_image(4, $urandom_range(0, 3) == 0);
			end
			IMG_BAD_HCRC: begin
				build_image(cur_sig, $urandom, 0, kind);
				play_image(32, $urandom_range(0, 3) == 0);
			end
			default: begin
				build_image(cur_sig, data_len, data_len, kind);
				play_image(image_q.size(), $urandom_range(0, 3) == 0);
			end
		endcase
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_verdicts != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_signature(input logic [31:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_sig = value;
		sig_settings++;
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if ($urandom_range(0, 15) == 0)
					receiver_burst = !receiver_burst;
				stall = receiver_burst ? 0 : $urandom_range(0, 10);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes without a start in idle
		offer_byte(8'hFF, 1'b0, 1'b0);
		offer_byte(8'h00, 1'b0, 1'b0);
		// all-zero signature against the reset value
		for (int i = 0; i < 4; i++)
			offer_byte(8'h00, i == 0, 1'b1);
		// abandoned header, then a restart with a zero-length payload
		build_image(cur_sig, 32'd0, 0, IMG_GOOD);
		offer_byte(image_q[0], 1'b1, 1'b1);
		offer_byte(image_q[1], 1'b0, 1'b1);
		play_image(image_q.size(), 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				write_signature((p == 1) ? 32'h0 : (p == 2) ? 32'hFFFF_FFFF :
					(p == PHASES - 1) ? SIG_RESET : $urandom);
			if (p == 2) begin
				// stall the result side and keep pushing short images
				hold_req = 1'b1;
				sender_burst = 1'b1;
				repeat (12) begin
					build_image(cur_sig, 32'd0, 0, IMG_BAD_SIG);
					play_image(4, 1'b0);
				end
				sender_burst = 1'b0;
			end
			while (bytes_sent < (p + 1) * TARGET_BYTES / PHASES ||
				(p == PHASES - 1 && verdicts_checked + pending_verdicts < MIN_VERDICTS))
				random_image();
		end

		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		for (int w = 0; w < 5000 && pending_verdicts != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_verdicts != 0)
			$error("%0d verdicts never delivered", pending_verdicts);
		$display("Streamed %0d image bytes under %0d signature settings.", bytes_sent, sig_settings);
		$display("Checked %0d verdicts, %0d of them valid images.", verdicts_checked, valid_verdicts);
		if (fail_count == 0 && pending_verdicts == 0)
			$display("PASS boot_image_crc_validator_unit");
		else
			$display("FAIL boot_image_crc_validator_unit");
		$finish;
	end

endmodule

// File: boot_image_crc_validator_unit.f
+incdir+rtl
rtl/bicv_pkg.sv
rtl/bicv_core.sv
rtl/bicv_out_stage.sv
rtl/boot_image_crc_validator_unit.sv
test/image_verdict_checker.sv
test/boot_image_crc_validator_unit_tb.sv
